@@ hw/rtl/atomic_memory_unit_lr_sc_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef ATOMIC_MEMORY_UNIT_LR_SC_UNIT_ASSERT_SVH
`define ATOMIC_MEMORY_UNIT_LR_SC_UNIT_ASSERT_SVH

// property checked at every clock edge outside reset
`define AMU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define AMU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/amu_lrsc_pkg.sv @@
`timescale 1ns / 1ps

package amu_lrsc_pkg;

  // default store depth in words
  localparam int MEM_WORDS_DEF = 1024;

  // word fields
  localparam int FUNC_W   = 3;
  localparam int BADDR_W  = 12;
  localparam int WADDR_W  = BADDR_W - 2;
  localparam int DATA_W   = 32;
  localparam int IN_W     = 48;
  localparam int KCNT_W   = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_AND  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_OR   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_XOR  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SWAP = 3'd4;
  localparam logic [FUNC_W-1:0] FN_LR   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SC   = 3'd6;

  // store-conditional result codes
  localparam logic [DATA_W-1:0] SC_OK   = 32'd0;
  localparam logic [DATA_W-1:0] SC_FAIL = 32'd1;

  // control into the combine unit
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              res_hit;
  } alu_ctrl_t;

  // decisions out of the combine unit
  typedef struct packed {
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_value;
    logic              res_set;
    logic              res_clear;
  } alu_res_t;

  // number of subtract steps that reduce a word address modulo the depth
  function automatic int red_steps(input int m);
    int n;
    n = 0;
    if (m < (1 << WADDR_W)) begin
      while ((m << n) < (1 << WADDR_W)) n = n + 1;
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/amu_lrsc_alu.sv @@
`timescale 1ns / 1ps

module amu_lrsc_alu (
  input  amu_lrsc_pkg::alu_ctrl_t                 ctrl,
  input  logic [amu_lrsc_pkg::DATA_W-1:0]         old_word,
  input  logic [amu_lrsc_pkg::DATA_W-1:0]         operand,
  output amu_lrsc_pkg::alu_res_t                  res
);

  // decode the operation into write, result and reservation actions
  always_comb begin
    res.wr_en     = 1'b0;
    res.wr_data   = operand;
    res.rd_value  = old_word;
    res.res_set   = 1'b0;
    res.res_clear = 1'b0;
    unique case (ctrl.func)
      amu_lrsc_pkg::FN_ADD: begin
        res.wr_en   = 1'b1;
        res.wr_data = old_word + operand;
      end
      amu_lrsc_pkg::FN_AND: begin
        res.wr_en   = 1'b1;
        res.wr_data = old_word & operand;
      end
      amu_lrsc_pkg::FN_OR: begin
        res.wr_en   = 1'b1;
        res.wr_data = old_word | operand;
      end
      amu_lrsc_pkg::FN_XOR: begin
        res.wr_en   = 1'b1;
        res.wr_data = old_word ^ operand;
      end
      amu_lrsc_pkg::FN_SWAP: begin
        res.wr_en = 1'b1;
      end
      amu_lrsc_pkg::FN_LR: begin
        res.res_set = 1'b1;
      end
      amu_lrsc_pkg::FN_SC: begin
        res.res_clear = 1'b1;
        res.wr_en     = ctrl.res_hit;
        res.rd_value  = ctrl.res_hit ? amu_lrsc_pkg::SC_OK : amu_lrsc_pkg::SC_FAIL;
      end
      default: begin
        // unused code acts as a plain load
      end
    endcase
  end

endmodule

@@ hw/rtl/atomic_memory_unit_lr_sc_unit.sv @@
`timescale 1ns / 1ps

// Atomic memory unit: executes one 32-bit atomic request per input word (add, and, or,
// xor, swap, load-reserved, store-conditional) against a MEM_WORDS x 32 store held in a
// single-port-write synchronous RAM, and returns one result word per request. After reset
// the RAM is swept to zero, one word per cycle, with s_tready low. When MEM_WORDS >= 1024 a
// request goes through two steps: accept and issue the RAM read, then combine, write back
// and load the output register once that register is free. For smaller depths the word
// address is first reduced modulo MEM_WORDS by a shared compare-and-subtract step, applied
// once for each shifted copy of MEM_WORDS below 1024, and the RAM read then gets a state of
// its own. Requests are handled one at a time on the single RAM; a new request is taken
// while the previous result waits on m_tready.

module atomic_memory_unit_lr_sc_unit #(
  parameter int MEM_WORDS = amu_lrsc_pkg::MEM_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // func [2:0], byte_address [14:3], operand [46:15], zero [47]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [amu_lrsc_pkg::IN_W-1:0]     s_tdata,
  // rd_value [31:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [amu_lrsc_pkg::DATA_W-1:0]   m_tdata
);

  localparam int IDX_W  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int NSTEP  = amu_lrsc_pkg::red_steps(MEM_WORDS);
  localparam bit RED_EN = (NSTEP > 0);
  localparam logic [amu_lrsc_pkg::WADDR_W-1:0] MOD_C =
    RED_EN ? amu_lrsc_pkg::WADDR_W'(MEM_WORDS) : '0;
  localparam logic [amu_lrsc_pkg::KCNT_W-1:0] KTOP =
    RED_EN ? amu_lrsc_pkg::KCNT_W'(NSTEP - 1) : '0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_EXEC
  } state_t;

  state_t                                 state;
  logic [IDX_W-1:0]                       clr_cnt;
  logic [amu_lrsc_pkg::KCNT_W-1:0]        kcnt;
  logic [amu_lrsc_pkg::WADDR_W-1:0]       rem;
  logic [amu_lrsc_pkg::WADDR_W-1:0]       waddr;
  logic [amu_lrsc_pkg::FUNC_W-1:0]        func;
  logic [amu_lrsc_pkg::DATA_W-1:0]        operand;
  logic                                   res_valid;
  logic [amu_lrsc_pkg::WADDR_W-1:0]       res_word;

  logic [amu_lrsc_pkg::DATA_W-1:0]        mem [MEM_WORDS];
  logic [amu_lrsc_pkg::DATA_W-1:0]        mem_q;

  logic                                   accept;
  logic                                   out_free;
  logic                                   exec_go;
  logic [amu_lrsc_pkg::WADDR_W-1:0]       in_waddr;
  logic [amu_lrsc_pkg::WADDR_W-1:0]       sub_c;
  logic [IDX_W-1:0]                       item_idx;
  logic [IDX_W-1:0]                       rd_idx;
  logic [IDX_W-1:0]                       wr_idx;
  logic                                   mem_re;
  logic                                   mem_we;
  logic [amu_lrsc_pkg::DATA_W-1:0]        mem_wdata;
  amu_lrsc_pkg::alu_ctrl_t                alu_ctrl;
  amu_lrsc_pkg::alu_res_t                 alu_res;

  // handshake and address decode
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign exec_go  = (state == ST_EXEC) && out_free;
  assign in_waddr = s_tdata[amu_lrsc_pkg::FUNC_W + 2 +: amu_lrsc_pkg::WADDR_W];
  assign sub_c    = MOD_C << kcnt;
  assign item_idx = IDX_W'(rem);

  // ram port control
  assign rd_idx    = (state == ST_IDLE) ? IDX_W'(in_waddr) : item_idx;
  assign mem_re    = (accept && !RED_EN) || (state == ST_READ);
  assign wr_idx    = (state == ST_CLEAR) ? clr_cnt : item_idx;
  assign mem_we    = (state == ST_CLEAR) || (exec_go && alu_res.wr_en);
  assign mem_wdata = (state == ST_CLEAR) ? '0 : alu_res.wr_data;

  // combine unit
  assign alu_ctrl.func    = func;
  assign alu_ctrl.res_hit = res_valid && (res_word == waddr);

  amu_lrsc_alu u_alu (
    .ctrl     (alu_ctrl),
    .old_word (mem_q),
    .operand  (operand),
    .res      (alu_res)
  );

  // word store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[rd_idx];
    end
  end

  // sequencer, reservation and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      kcnt      <= '0;
      res_valid <= 1'b0;
      res_word  <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !exec_go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            func    <= s_tdata[0 +: amu_lrsc_pkg::FUNC_W];
            operand <= s_tdata[amu_lrsc_pkg::FUNC_W + amu_lrsc_pkg::BADDR_W +:
                               amu_lrsc_pkg::DATA_W];
            waddr   <= in_waddr;
            rem     <= in_waddr;
            kcnt    <= KTOP;
            state   <= RED_EN ? ST_REDUCE : ST_EXEC;
          end
        end
        ST_REDUCE: begin
          // one restoring subtract step of the modulo reduction
          if (rem >= sub_c) begin
            rem <= rem - sub_c;
          end
          if (kcnt == '0) begin
            state <= ST_READ;
          end else begin
            kcnt <= kcnt - 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= alu_res.rd_value;
            if (alu_res.res_set) begin
              res_valid <= 1'b1;
              res_word  <= waddr;
            end else if (alu_res.res_clear) begin
              res_valid <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/amu_lrsc_chk.sv @@
`timescale 1ns / 1ps

`include "atomic_memory_unit_lr_sc_unit_assert.svh"

module amu_lrsc_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [amu_lrsc_pkg::IN_W-1:0]     s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [amu_lrsc_pkg::DATA_W-1:0]   m_tdata
);

  // the clearing sweep holds off requests right after reset
  `AMU_ASSERT_ALWAYS(a_no_accept_after_rst, rst |=> !s_tready, "request taken during clear")

  // one request in flight: an accepted word closes the input until its result is loaded
  `AMU_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second request overlapped")

  // a new result is only produced while the input is closed
  `AMU_ASSERT(a_result_from_exec, $rose(m_tvalid) |-> !$past(s_tready), "result without request")

  // a stalled result word holds
  `AMU_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result dropped")

endmodule

bind atomic_memory_unit_lr_sc_unit amu_lrsc_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
